// ===== rtl/jitl_pkg.sv =====
// ----------------------------------------------------------------------------
// jitl_pkg
// Shared types, constants and per-joint limit tables of the joint impedance
// torque limiter.
// ----------------------------------------------------------------------------
package jitl_pkg;

	localparam int ROM_JOINTS = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int MUL_W      = 27;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int ACC_W      = 40;

	localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 3'd4;

	localparam logic [15:0] KP_RESET    = 16'd25600;
	localparam logic [15:0] KD_RESET    = 16'd2560;
	localparam logic [16:0] ALPHA_RESET = 17'd64881;
	localparam logic [12:0] STEP_RESET  = 13'd8;
	localparam logic [15:0] RATE_RESET  = 16'd128;

	localparam logic [16:0] ALPHA_ONE   = 17'd65536;
	localparam logic [32:0] DIV_BIAS    = 33'd500;
	// ceil(2^35 / 1000), exact for dividends below 2^25
	localparam logic [25:0] RECIP_1000  = 26'd34359739;
	localparam int          RECIP_SHIFT = 35;
	localparam logic signed [16:0] MAXD_SAT = 17'sd65535;
	localparam logic signed [14:0] TAU_MAX  = 15'sd11136;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SLEW,
		S_FV1,
		S_FV2,
		S_FVR,
		S_TK,
		S_TD,
		S_RT,
		S_RM,
		S_RQ,
		S_DONE
	} state_t;

	function automatic logic signed [15:0] pos_hi(input logic [2:0] j);
		logic signed [15:0] v;
		unique case (j)
			3'd0: v = 16'sd11867;
			3'd1: v = 16'sd7220;
			3'd2: v = 16'sd11867;
			3'd3: v = -16'sd286;
			3'd4: v = 16'sd11867;
			3'd5: v = 16'sd15370;
			3'd6: v = 16'sd11867;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] pos_lo(input logic [2:0] j);
		logic signed [15:0] v;
		unique case (j)
			3'd0: v = -16'sd11867;
			3'd1: v = -16'sd7220;
			3'd2: v = -16'sd11867;
			3'd3: v = -16'sd12582;
			3'd4: v = -16'sd11867;
			3'd5: v = -16'sd72;
			3'd6: v = -16'sd11867;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [14:0] tau_lim(input logic [2:0] j);
		logic signed [14:0] v;
		unique case (j)
			3'd0, 3'd1, 3'd2, 3'd4: v = TAU_MAX;
			3'd3, 3'd5, 3'd6: v = 15'sd1536;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/jitl_if.sv =====
// ----------------------------------------------------------------------------
// jitl_if
// Valid/ready channels of the joint impedance torque limiter: control tick
// words in, torque command words out.
// ----------------------------------------------------------------------------
interface jitl_cmd_if;
	logic valid;
	logic ready;
	logic [2:0] joint_index;
	logic signed [15:0] target_position;
	logic signed [15:0] measured_position;
	logic signed [15:0] measured_velocity;
	logic [15:0] period_us;

	modport source (
		output valid, joint_index, target_position, measured_position,
		measured_velocity, period_us,
		input ready
	);
	modport sink (
		input valid, joint_index, target_position, measured_position,
		measured_velocity, period_us,
		output ready
	);
endinterface

interface jitl_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] joint_out;
	logic signed [14:0] torque;

	modport source (output valid, joint_out, torque, input ready);
	modport sink (input valid, joint_out, torque, output ready);
endinterface

// ===== rtl/jitl_mul.sv =====
// ----------------------------------------------------------------------------
// jitl_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module jitl_mul (
	input  logic clk,
	input  logic signed [jitl_pkg::MUL_W-1:0] a,
	input  logic signed [jitl_pkg::MUL_W-1:0] b,
	output logic signed [jitl_pkg::PROD_W-1:0] p
);

	logic signed [jitl_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ===== rtl/joint_impedance_torque_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// joint_impedance_torque_limiter_unit
// Per-joint target clamp and slew, velocity low-pass, PD torque, torque
// saturation and rate limit, all on one shared multiplier.
// The sequencer accepts no new input word until the last result has been loaded
// into the output register; an in-range joint makes six passes through the single
// multiplier, and a stalled output holds the sequencer.
// Reset: config registers return to defaults, every joint marked not started.
// ----------------------------------------------------------------------------
module joint_impedance_torque_limiter_unit #(
	parameter int NUM_JOINTS = 7
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [jitl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jitl_pkg::CFG_DATA_W-1:0] cfg_data,
	jitl_cmd_if.sink cmd,
	jitl_rsp_if.source rsp
);

	localparam int NSTORE = (NUM_JOINTS < jitl_pkg::ROM_JOINTS) ? NUM_JOINTS
		: jitl_pkg::ROM_JOINTS;
	localparam int IDXW = (NSTORE > 1) ? $clog2(NSTORE) : 1;

	jitl_pkg::state_t state_q, state_d;

	logic [15:0] kp_q, kd_q, rate_q;
	logic [16:0] alpha_q;
	logic [12:0] step_q;

	logic [2:0] joint_q;
	logic signed [15:0] target_q, meas_q, vel_q;
	logic [15:0] period_q;
	logic ok_q;
	logic signed [15:0] tgt_q, des_q, vf_old_q, vf_new_q;
	logic signed [14:0] last_q, t_q, tq_q;
	logic signed [jitl_pkg::ACC_W-1:0] acc_q;
	logic [24:0] x_q;
	logic sat_q;

	logic signed [15:0] des_mem_q [NSTORE];
	logic signed [15:0] vf_mem_q [NSTORE];
	logic signed [14:0] last_mem_q [NSTORE];
	logic [NSTORE-1:0] started_q;

	logic rsp_valid_q;
	logic [2:0] rsp_joint_q;
	logic signed [14:0] rsp_torque_q;

	logic signed [jitl_pkg::MUL_W-1:0] mul_a, mul_b;
	logic signed [jitl_pkg::PROD_W-1:0] prod;

	logic [IDXW-1:0] idx;
	logic jok, st_c, slot_free;
	logic signed [15:0] lo_c, hi_c, tgt_c, slew_c;
	logic signed [16:0] diff_c, step_c, e_c;
	logic [16:0] a_eff, om_c;
	logic signed [jitl_pkg::ACC_W-1:0] fsum_c, frnd_c, tsum_c, trnd_c;
	logic signed [24:0] tfull_c;
	logic signed [14:0] lim_c, tclamp_c;
	logic [32:0] x_c;
	logic [15:0] q_c;
	logic signed [17:0] maxd_c, d_c, tf_c;

	jitl_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign idx = joint_q[IDXW-1:0];
	assign jok = joint_q < 3'(NSTORE);
	assign st_c = jok && started_q[idx];
	assign slot_free = !rsp_valid_q || rsp.ready;

	// clamp and slew
	assign lo_c = jitl_pkg::pos_lo(joint_q);
	assign hi_c = jitl_pkg::pos_hi(joint_q);
	assign tgt_c = (target_q < lo_c) ? lo_c : ((target_q > hi_c) ? hi_c : target_q);
	assign diff_c = 17'(tgt_q) - 17'(des_q);
	assign step_c = signed'({4'b0, step_q});
	always_comb begin
		if (diff_c > step_c) begin
			slew_c = 16'(17'(des_q) + step_c);
		end else if (diff_c < -step_c) begin
			slew_c = 16'(17'(des_q) - step_c);
		end else begin
			slew_c = tgt_q;
		end
	end

	// filter and impedance law
	assign a_eff = (alpha_q > jitl_pkg::ALPHA_ONE) ? jitl_pkg::ALPHA_ONE : alpha_q;
	assign om_c = jitl_pkg::ALPHA_ONE - a_eff;
	assign e_c = 17'(des_q) - 17'(meas_q);
	assign fsum_c = acc_q + prod[jitl_pkg::ACC_W-1:0];
	assign frnd_c = fsum_c + 40'sd32768;
	assign tsum_c = acc_q - signed'({prod[jitl_pkg::ACC_W-5:0], 4'b0});
	assign trnd_c = tsum_c + 40'sd16384;
	assign tfull_c = trnd_c[39:15];
	assign lim_c = jitl_pkg::tau_lim(joint_q);
	always_comb begin
		if (tfull_c > 25'(lim_c)) begin
			tclamp_c = lim_c;
		end else if (tfull_c < -25'(lim_c)) begin
			tclamp_c = -lim_c;
		end else begin
			tclamp_c = tfull_c[14:0];
		end
	end

	// rate limit
	assign x_c = {1'b0, prod[31:0]} + jitl_pkg::DIV_BIAS;
	assign q_c = prod[jitl_pkg::RECIP_SHIFT+15:jitl_pkg::RECIP_SHIFT];
	assign maxd_c = sat_q ? 18'(jitl_pkg::MAXD_SAT) : signed'({2'b0, q_c});
	assign d_c = 18'(t_q) - 18'(last_q);
	always_comb begin
		if (d_c > maxd_c) begin
			tf_c = 18'(last_q) + maxd_c;
		end else if (d_c < -maxd_c) begin
			tf_c = 18'(last_q) - maxd_c;
		end else begin
			tf_c = 18'(t_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			jitl_pkg::S_IDLE: if (cmd.valid) state_d = jitl_pkg::S_SLEW;
			jitl_pkg::S_SLEW: state_d = jok ? jitl_pkg::S_FV1 : jitl_pkg::S_DONE;
			jitl_pkg::S_FV1: state_d = jitl_pkg::S_FV2;
			jitl_pkg::S_FV2: state_d = jitl_pkg::S_FVR;
			jitl_pkg::S_FVR: state_d = jitl_pkg::S_TK;
			jitl_pkg::S_TK: state_d = jitl_pkg::S_TD;
			jitl_pkg::S_TD: state_d = jitl_pkg::S_RT;
			jitl_pkg::S_RT: state_d = jitl_pkg::S_RM;
			jitl_pkg::S_RM: state_d = jitl_pkg::S_RQ;
			jitl_pkg::S_RQ: state_d = jitl_pkg::S_DONE;
			jitl_pkg::S_DONE: if (slot_free) state_d = jitl_pkg::S_IDLE;
			default: state_d = jitl_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			jitl_pkg::S_IDLE: cmd.ready = 1'b1;
			jitl_pkg::S_FV1: begin
				mul_a = signed'({10'b0, om_c});
				mul_b = 27'(vf_old_q);
			end
			jitl_pkg::S_FV2: begin
				mul_a = signed'({10'b0, a_eff});
				mul_b = 27'(vel_q);
			end
			jitl_pkg::S_FVR: begin
				mul_a = signed'({11'b0, kp_q});
				mul_b = 27'(e_c);
			end
			jitl_pkg::S_TK: begin
				mul_a = signed'({11'b0, kd_q});
				mul_b = 27'(vf_new_q);
			end
			jitl_pkg::S_TD: begin
				mul_a = signed'({11'b0, rate_q});
				mul_b = signed'({11'b0, period_q});
			end
			jitl_pkg::S_RM: begin
				mul_a = signed'({2'b0, x_q});
				mul_b = signed'({1'b0, jitl_pkg::RECIP_1000});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jitl_pkg::S_IDLE;
			started_q <= '0;
			rsp_valid_q <= 1'b0;
			kp_q <= jitl_pkg::KP_RESET;
			kd_q <= jitl_pkg::KD_RESET;
			alpha_q <= jitl_pkg::ALPHA_RESET;
			step_q <= jitl_pkg::STEP_RESET;
			rate_q <= jitl_pkg::RATE_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_index)
					jitl_pkg::CFG_KP: kp_q <= cfg_data[15:0];
					jitl_pkg::CFG_KD: kd_q <= cfg_data[15:0];
					jitl_pkg::CFG_ALPHA: alpha_q <= cfg_data;
					jitl_pkg::CFG_STEP: step_q <= cfg_data[12:0];
					jitl_pkg::CFG_RATE: rate_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == jitl_pkg::S_RQ && ok_q) begin
				started_q[idx] <= 1'b1;
			end
			if (state_q == jitl_pkg::S_DONE && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			jitl_pkg::S_IDLE: begin
				joint_q <= cmd.joint_index;
				target_q <= cmd.target_position;
				meas_q <= cmd.measured_position;
				vel_q <= cmd.measured_velocity;
				period_q <= cmd.period_us;
			end
			jitl_pkg::S_SLEW: begin
				ok_q <= jok;
				tgt_q <= tgt_c;
				des_q <= st_c ? des_mem_q[idx] : meas_q;
				vf_old_q <= st_c ? vf_mem_q[idx] : '0;
				last_q <= st_c ? last_mem_q[idx] : '0;
				tq_q <= '0;
			end
			jitl_pkg::S_FV1: des_q <= slew_c;
			jitl_pkg::S_FV2: acc_q <= prod[jitl_pkg::ACC_W-1:0];
			jitl_pkg::S_FVR: vf_new_q <= frnd_c[31:16];
			jitl_pkg::S_TK: acc_q <= signed'({prod[jitl_pkg::ACC_W-3:0], 2'b0});
			jitl_pkg::S_TD: t_q <= tclamp_c;
			jitl_pkg::S_RT: begin
				sat_q <= |x_c[32:25];
				x_q <= x_c[24:0];
			end
			jitl_pkg::S_RQ: begin
				tq_q <= tf_c[14:0];
				if (ok_q) begin
					des_mem_q[idx] <= des_q;
					vf_mem_q[idx] <= vf_new_q;
					last_mem_q[idx] <= tf_c[14:0];
				end
			end
			jitl_pkg::S_DONE: begin
				if (slot_free) begin
					rsp_joint_q <= joint_q;
					rsp_torque_q <= tq_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.joint_out = rsp_joint_q;
	assign rsp.torque = rsp_torque_q;

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jitl_pkg::S_DONE && slot_free) |=>
			(rsp_valid_q && state_q == jitl_pkg::S_IDLE))
		else $error("result word not presented after done");

	a_rise_only_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == jitl_pkg::S_DONE))
		else $error("result word appeared outside done");

	a_torque_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_torque_q <= jitl_pkg::TAU_MAX &&
			rsp_torque_q >= -jitl_pkg::TAU_MAX))
		else $error("torque beyond limit");

	a_started_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (($past(started_q) & ~started_q) == '0))
		else $error("joint start flag cleared");

	a_bad_joint_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jitl_pkg::S_DONE && !ok_q) |-> (tq_q == '0))
		else $error("out of range joint gave nonzero torque");

endmodule
